### hdl/afva_pkg.sv
// ----------------------------------------------------------------------------
// afva_pkg: shared types, constants and helpers of the audio sample buffer
// Sizes, register indexes, item codes and pointer arithmetic for the ring.
// ----------------------------------------------------------------------------
package afva_pkg;

   localparam int unsigned DEPTH        = 2048;
   localparam int unsigned PRIME_OFFSET = 256;
   localparam int unsigned PTR_W        = $clog2(DEPTH);

   localparam int unsigned SAMPLE_W     = 8;
   localparam int unsigned VOLUME_W     = 4;
   localparam int unsigned FILL_W       = 11;
   localparam int unsigned HEADROOM_W   = 11;
   localparam int unsigned HOLD_W       = 8;
   localparam int unsigned CSR_IDX_W    = 2;
   localparam int unsigned CSR_DATA_W   = 11;
   localparam int unsigned SHIFT_W      = 3;

   localparam int unsigned SUM_W = ((PTR_W > HEADROOM_W) ? PTR_W : HEADROOM_W) + 1;

   localparam logic [SAMPLE_W-1:0]   MID_SCALE    = SAMPLE_W'(128);
   localparam logic [VOLUME_W-1:0]   MAX_VOL      = VOLUME_W'(7);
   localparam logic [HEADROOM_W-1:0] HEADROOM_RST = HEADROOM_W'(400);
   localparam logic [HOLD_W-1:0]     HOLD_RST     = HOLD_W'(11);
   localparam logic [PTR_W-1:0]      PRIME_PTR    = PTR_W'(PRIME_OFFSET % DEPTH);

   typedef logic [PTR_W-1:0] ptr_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROOM_HEADROOM   = 2'd0,
      CSR_AMP_HOLD_FRAMES = 2'd1
   } csr_index_type;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_READ = 1'b1;

   // advance a ring pointer, wrapping at DEPTH
   function automatic ptr_type ptr_inc(input ptr_type p);
      ptr_type r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   // (a - b) modulo DEPTH
   function automatic ptr_type ptr_sub(input ptr_type a, input ptr_type b);
      logic [PTR_W:0] d;
      d = {1'b0, a} - {1'b0, b};
      if (d[PTR_W]) begin
         d = d + (PTR_W+1)'(DEPTH);
      end
      return d[PTR_W-1:0];
   endfunction

   // scale about mid-scale: floor shift of the signed offset by (7 - volume), volume capped at 7
   function automatic logic [SAMPLE_W-1:0] scale_sample(input logic [SAMPLE_W-1:0] s,
                                                        input logic [VOLUME_W-1:0] vol);
      logic [VOLUME_W-1:0] v;
      logic [SHIFT_W-1:0]  k;
      logic signed [SAMPLE_W-1:0] d;
      logic signed [SAMPLE_W-1:0] q;
      v = (vol > MAX_VOL) ? MAX_VOL : vol;
      k = SHIFT_W'(MAX_VOL - v);
      d = $signed(s ^ MID_SCALE);
      q = d >>> k;
      return $unsigned(q) ^ MID_SCALE;
   endfunction

endpackage

### hdl/audio_fifo_volume_amp_gate.sv
// ----------------------------------------------------------------------------
// audio_fifo_volume_amp_gate: audio sample ring buffer with volume and amp gate
// Pushes store samples (mid-scale when volume is zero), read ticks return volume-scaled samples; every beat
// reports fill level, room flag and amplifier state.
// ----------------------------------------------------------------------------
// Pipeline: memory read stage, then result register. Throughput: one beat per
// cycle while the result side is not stalled, set by the single memory port.
// Reset is synchronous; the sample store is not swept. A saturating push count
// marks which entries have been written, and unwritten entries read as zero.
// ----------------------------------------------------------------------------
module audio_fifo_volume_amp_gate (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [afva_pkg::SAMPLE_W-1:0]        req_sample,
   input  logic [afva_pkg::VOLUME_W-1:0]        req_volume,
   input  logic                                 req_frame_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [afva_pkg::SAMPLE_W-1:0]        rsp_dac_sample,
   output logic [afva_pkg::FILL_W-1:0]          rsp_fill_level,
   output logic                                 rsp_has_room,
   output logic                                 rsp_amp_enable,
   input  logic                                 csr_wr_en,
   input  logic [afva_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [afva_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int unsigned PTR_W = afva_pkg::PTR_W;

   logic [afva_pkg::SAMPLE_W-1:0] mem_ff [afva_pkg::DEPTH];

   afva_pkg::ptr_type                wp_ff, wp_in;
   afva_pkg::ptr_type                rp_ff, rp_in;
   logic [PTR_W:0]                   push_cnt_ff, push_cnt_in;
   logic [afva_pkg::VOLUME_W-1:0]    vol_ff, vol_in;
   logic [afva_pkg::HOLD_W-1:0]      cnt_ff, cnt_in;
   logic                             amp_ff, amp_in;
   logic [afva_pkg::HEADROOM_W-1:0]  headroom_ff;
   logic [afva_pkg::HOLD_W-1:0]      hold_ff;

   // read stage
   logic                             s1_valid_ff;
   logic                             s1_read_ff;
   logic                             s1_written_ff;
   logic [afva_pkg::SAMPLE_W-1:0]    s1_data_ff;
   logic [afva_pkg::VOLUME_W-1:0]    s1_vol_ff;
   afva_pkg::ptr_type                s1_fill_ff;
   logic                             s1_room_ff;
   logic                             s1_amp_ff;

   // result register
   logic                             rsp_valid_ff;
   logic [afva_pkg::SAMPLE_W-1:0]    rsp_dac_ff, rsp_dac_in;
   logic [afva_pkg::FILL_W-1:0]      rsp_fill_ff;
   logic                             rsp_room_ff;
   logic                             rsp_amp_ff;

   logic                             accept;
   logic                             is_push;
   logic                             s1_move;
   logic                             written;
   afva_pkg::ptr_type                fill;
   logic                             room;
   logic [afva_pkg::SAMPLE_W-1:0]    store_val;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;
   assign is_push   = (req_mode == afva_pkg::MODE_PUSH);
   assign store_val = (req_volume != '0) ? req_sample : afva_pkg::MID_SCALE;

   // entry at the read pointer holds data once enough pushes have covered it
   assign written = {1'b0, afva_pkg::ptr_sub(rp_ff, afva_pkg::PRIME_PTR)} < push_cnt_ff;

   always_comb begin
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      push_cnt_in = push_cnt_ff;
      vol_in      = vol_ff;
      cnt_in      = cnt_ff;
      amp_in      = amp_ff;
      if (is_push) begin
         wp_in  = afva_pkg::ptr_inc(wp_ff);
         vol_in = req_volume;
         if (push_cnt_ff != (PTR_W+1)'(afva_pkg::DEPTH)) begin
            push_cnt_in = push_cnt_ff + (PTR_W+1)'(1);
         end
         if (req_frame_end) begin
            if (req_volume != '0) begin
               amp_in = 1'b1;
               cnt_in = hold_ff;
            end else begin
               if (cnt_ff == afva_pkg::HOLD_W'(1)) begin
                  amp_in = 1'b0;
               end
               if (cnt_ff != '0) begin
                  cnt_in = cnt_ff - afva_pkg::HOLD_W'(1);
               end
            end
         end
      end else begin
         rp_in = afva_pkg::ptr_inc(rp_ff);
      end
      fill = afva_pkg::ptr_sub(wp_in, rp_in);
      room = (afva_pkg::SUM_W'(fill) + afva_pkg::SUM_W'(headroom_ff))
             < afva_pkg::SUM_W'(afva_pkg::DEPTH);
   end

   // sample store: one write or one registered read per beat
   always_ff @(posedge clock) begin
      if (accept) begin
         if (is_push) begin
            mem_ff[wp_ff] <= store_val;
         end else begin
            s1_data_ff <= mem_ff[rp_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= afva_pkg::PRIME_PTR;
         rp_ff       <= '0;
         push_cnt_ff <= '0;
         vol_ff      <= '0;
         cnt_ff      <= '0;
         amp_ff      <= 1'b0;
      end else if (accept) begin
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         push_cnt_ff <= push_cnt_in;
         vol_ff      <= vol_in;
         cnt_ff      <= cnt_in;
         amp_ff      <= amp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         headroom_ff <= afva_pkg::HEADROOM_RST;
         hold_ff     <= afva_pkg::HOLD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            afva_pkg::CSR_ROOM_HEADROOM: begin
               headroom_ff <= csr_wr_data[afva_pkg::HEADROOM_W-1:0];
            end
            afva_pkg::CSR_AMP_HOLD_FRAMES: begin
               hold_ff <= csr_wr_data[afva_pkg::HOLD_W-1:0];
            end
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_read_ff    <= !is_push;
         s1_written_ff <= written;
         s1_vol_ff     <= vol_ff;
         s1_fill_ff    <= fill;
         s1_room_ff    <= room;
         s1_amp_ff     <= amp_in;
      end
   end

   always_comb begin
      rsp_dac_in = '0;
      if (s1_read_ff) begin
         rsp_dac_in = afva_pkg::scale_sample(s1_written_ff ? s1_data_ff : '0, s1_vol_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_dac_ff  <= rsp_dac_in;
         rsp_fill_ff <= afva_pkg::FILL_W'(s1_fill_ff);
         rsp_room_ff <= s1_room_ff;
         rsp_amp_ff  <= s1_amp_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dac_sample = rsp_dac_ff;
   assign rsp_fill_level = rsp_fill_ff;
   assign rsp_has_room   = rsp_room_ff;
   assign rsp_amp_enable = rsp_amp_ff;

endmodule

### tb/tb_audio_fifo_volume_amp_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_fifo_volume_amp_gate: self-checking bench for the audio sample ring
// Drives pushes and read ticks through valid/ready, predicts every result beat
// (scaled sample, fill level, room flag, amp state) with a local ring model,
// and steps the two control registers through their extremes between phases.
// ----------------------------------------------------------------------------
module tb_audio_fifo_volume_amp_gate;

   typedef struct packed {
      logic                          mode;
      logic [afva_pkg::SAMPLE_W-1:0] sample;
      logic [afva_pkg::VOLUME_W-1:0] volume;
      logic                          frame_end;
   } pcm_req_type;

   typedef struct packed {
      logic [afva_pkg::SAMPLE_W-1:0] dac_sample;
      logic [afva_pkg::FILL_W-1:0]   fill_level;
      logic                          has_room;
      logic                          amp_enable;
   } pcm_rsp_type;

   localparam logic [afva_pkg::CSR_IDX_W-1:0] CSR_SPARE_IDX_A = 2'd2;
   localparam logic [afva_pkg::CSR_IDX_W-1:0] CSR_SPARE_IDX_B = 2'd3;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int MAX_BURST        = 19;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_mode = afva_pkg::MODE_PUSH;
   logic [afva_pkg::SAMPLE_W-1:0]   req_sample = '0;
   logic [afva_pkg::VOLUME_W-1:0]   req_volume = '0;
   logic                            req_frame_end = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [afva_pkg::SAMPLE_W-1:0]   rsp_dac_sample;
   logic [afva_pkg::FILL_W-1:0]     rsp_fill_level;
   logic                            rsp_has_room;
   logic                            rsp_amp_enable;
   logic                            csr_wr_en = 1'b0;
   logic [afva_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [afva_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   audio_fifo_volume_amp_gate dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_sample     (req_sample),
      .req_volume     (req_volume),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_dac_sample (rsp_dac_sample),
      .rsp_fill_level (rsp_fill_level),
      .rsp_has_room   (rsp_has_room),
      .rsp_amp_enable (rsp_amp_enable),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ring model state
   logic [afva_pkg::SAMPLE_W-1:0]   ring_mem [afva_pkg::DEPTH];
   afva_pkg::ptr_type               wr_ptr;
   afva_pkg::ptr_type               rd_ptr;
   logic [afva_pkg::VOLUME_W-1:0]   vol_latch;
   logic [afva_pkg::HOLD_W-1:0]     hold_count;
   logic                            amp_on_m;
   logic [afva_pkg::HEADROOM_W-1:0] room_cfg;
   logic [afva_pkg::HOLD_W-1:0]     hold_cfg;

   pcm_req_type pending_reqs [$];
   pcm_rsp_type awaited_beats [$];

   int  idle_odds = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_left = 0;
   bit  want_long_hold = 1'b0;
   bit  long_hold_done = 1'b0;
   int  mismatch_count = 0;

   function automatic afva_pkg::ptr_type ring_next(input afva_pkg::ptr_type p);
      return (p == afva_pkg::PTR_W'(afva_pkg::DEPTH - 1)) ? '0 : p + afva_pkg::PTR_W'(1);
   endfunction

   function automatic pcm_rsp_type predict_ring_step(input pcm_req_type it);
      pcm_rsp_type                   r;
      logic [afva_pkg::VOLUME_W-1:0] v;
      int                            offs;
      int                            sh;
      int                            fill;
      r = '0;
      if (it.mode == afva_pkg::MODE_PUSH) begin
         ring_mem[wr_ptr] = (it.volume != '0) ? it.sample : afva_pkg::MID_SCALE;
         wr_ptr = ring_next(wr_ptr);
         vol_latch = it.volume;
         if (it.frame_end) begin
            if (it.volume != '0) begin
               amp_on_m = 1'b1;
               hold_count = hold_cfg;
            end else begin
               if (hold_count == afva_pkg::HOLD_W'(1)) amp_on_m = 1'b0;
               if (hold_count != '0) hold_count = hold_count - afva_pkg::HOLD_W'(1);
            end
         end
      end else begin
         v = (vol_latch > afva_pkg::MAX_VOL) ? afva_pkg::MAX_VOL : vol_latch;
         sh = int'(afva_pkg::MAX_VOL - v);
         offs = int'(ring_mem[rd_ptr]) - int'(afva_pkg::MID_SCALE);
         // floor shift of the signed offset about mid-scale
         r.dac_sample = afva_pkg::SAMPLE_W'((offs >>> sh) + int'(afva_pkg::MID_SCALE));
         rd_ptr = ring_next(rd_ptr);
      end
      fill = (int'(wr_ptr) + int'(afva_pkg::DEPTH) - int'(rd_ptr)) % int'(afva_pkg::DEPTH);
      r.fill_level = afva_pkg::FILL_W'(fill);
      r.has_room = (fill + int'(room_cfg) < int'(afva_pkg::DEPTH));
      r.amp_enable = amp_on_m;
      return r;
   endfunction

   // sender: one beat per handshake, random gaps between beats
   always @(posedge clock) begin : drive_reqs
      pcm_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_beats.push_back(
               predict_ring_step('{req_mode, req_sample, req_volume, req_frame_end}));
            if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
               send_gap = $urandom_range(1, MAX_BURST);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               nxt = pending_reqs.pop_front();
               req_valid     <= 1'b1;
               req_mode      <= nxt.mode;
               req_sample    <= nxt.sample;
               req_volume    <= nxt.volume;
               req_frame_end <= nxt.frame_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: compare each beat with the oldest prediction, stall at random
   always @(posedge clock) begin : check_rsps
      pcm_rsp_type exp_beat;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_beats.size() == 0) begin
               $error("result beat with nothing pending: dac_sample %0d fill_level %0d",
                      rsp_dac_sample, rsp_fill_level);
               mismatch_count++;
            end else begin
               exp_beat = awaited_beats.pop_front();
               if (rsp_dac_sample !== exp_beat.dac_sample) begin
                  $error("dac_sample expected %0d got %0d",
                         exp_beat.dac_sample, rsp_dac_sample);
                  mismatch_count++;
               end
               if (rsp_fill_level !== exp_beat.fill_level) begin
                  $error("fill_level expected %0d got %0d",
                         exp_beat.fill_level, rsp_fill_level);
                  mismatch_count++;
               end
               if (rsp_has_room !== exp_beat.has_room) begin
                  $error("has_room expected %0d got %0d", exp_beat.has_room, rsp_has_room);
                  mismatch_count++;
               end
               if (rsp_amp_enable !== exp_beat.amp_enable) begin
                  $error("amp_enable expected %0d got %0d",
                         exp_beat.amp_enable, rsp_amp_enable);
                  mismatch_count++;
               end
            end
         end
         if (want_long_hold && !long_hold_done) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
               recv_gap = $urandom_range(1, MAX_BURST);
         end
      end
   end

   task automatic add_req(input logic mode, input int sample, input int volume,
                          input logic frame_end);
      pcm_req_type it;
      it.mode = mode;
      it.sample = afva_pkg::SAMPLE_W'(sample);
      it.volume = afva_pkg::VOLUME_W'(volume);
      it.frame_end = frame_end;
      pending_reqs.push_back(it);
   endtask

   // frames of pushes sharing one volume, read ticks mixed in, some noise
   task automatic queue_traffic(input int n_items, input int read_pct);
      int left;
      int flen;
      int fvol;
      left = n_items;
      while (left > 0) begin
         if ($urandom_range(0, 99) < 10) begin
            add_req(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                    $urandom_range(0, 15), 1'($urandom_range(0, 1)));
            left--;
         end else begin
            flen = $urandom_range(1, 8);
            fvol = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 15);
            for (int i = 0; i < flen && left > 0; i++) begin
               while (left > 0 && $urandom_range(0, 99) < read_pct) begin
                  add_req(afva_pkg::MODE_READ, $urandom_range(0, 255), $urandom_range(0, 15),
                          1'($urandom_range(0, 1)));
                  left--;
               end
               if (left > 0) begin
                  add_req(afva_pkg::MODE_PUSH, $urandom_range(0, 255), fvol, i == flen - 1);
                  left--;
               end
            end
         end
      end
   endtask

   // hold off new work until every beat has come back and the pipe is empty
   task automatic settle_ring();
      do begin
         @(negedge clock);
      end while (pending_reqs.size() != 0 || req_valid || awaited_beats.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [afva_pkg::CSR_IDX_W-1:0] idx,
                            input logic [afva_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         afva_pkg::CSR_ROOM_HEADROOM:   room_cfg = val[afva_pkg::HEADROOM_W-1:0];
         afva_pkg::CSR_AMP_HOLD_FRAMES: hold_cfg = val[afva_pkg::HOLD_W-1:0];
         default: ;
      endcase
   endtask

   initial begin : stimulus
      for (int i = 0; i < int'(afva_pkg::DEPTH); i++) ring_mem[i] = '0;
      wr_ptr     = afva_pkg::PRIME_PTR;
      rd_ptr     = '0;
      vol_latch  = '0;
      hold_count = '0;
      amp_on_m   = 1'b0;
      room_cfg   = afva_pkg::HEADROOM_RST;
      hold_cfg   = afva_pkg::HOLD_RST;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, silence, volume clamp, frame end on read
      idle_odds = 5;
      add_req(afva_pkg::MODE_READ, 0, 0, 1'b0);
      add_req(afva_pkg::MODE_PUSH, 255, 15, 1'b1);
      add_req(afva_pkg::MODE_READ, 255, 15, 1'b1);
      add_req(afva_pkg::MODE_PUSH, 0, 7, 1'b0);
      add_req(afva_pkg::MODE_READ, 0, 0, 1'b0);
      add_req(afva_pkg::MODE_PUSH, 128, 8, 1'b0);
      add_req(afva_pkg::MODE_READ, 128, 8, 1'b0);
      add_req(afva_pkg::MODE_PUSH, 127, 1, 1'b0);
      add_req(afva_pkg::MODE_READ, 127, 1, 1'b0);
      add_req(afva_pkg::MODE_PUSH, 1, 0, 1'b1);
      add_req(afva_pkg::MODE_READ, 1, 0, 1'b1);
      add_req(afva_pkg::MODE_PUSH, 200, 3, 1'b0);
      add_req(afva_pkg::MODE_PUSH, 0, 0, 1'b1);
      add_req(afva_pkg::MODE_PUSH, 255, 0, 1'b1);
      add_req(afva_pkg::MODE_READ, 0, 15, 1'b0);
      add_req(afva_pkg::MODE_PUSH, 129, 12, 1'b1);
      add_req(afva_pkg::MODE_READ, 255, 0, 1'b0);
      add_req(afva_pkg::MODE_PUSH, 85, 5, 1'b0);
      add_req(afva_pkg::MODE_PUSH, 170, 10, 1'b1);
      add_req(afva_pkg::MODE_READ, 170, 10, 1'b1);
      for (int i = 0; i < 5; i++) add_req(afva_pkg::MODE_PUSH, 64, 0, 1'b1);
      settle_ring();

      // no headroom, one-frame hold, read-heavy: drain and underrun the ring
      write_reg(afva_pkg::CSR_ROOM_HEADROOM, 11'd0);
      write_reg(afva_pkg::CSR_AMP_HOLD_FRAMES, 11'd1);
      idle_odds = 4;
      queue_traffic(450, 80);
      settle_ring();

      // full headroom, longest hold, no idling
      write_reg(afva_pkg::CSR_ROOM_HEADROOM, 11'd2047);
      write_reg(afva_pkg::CSR_AMP_HOLD_FRAMES, 11'd255);
      idle_odds = 0;
      queue_traffic(350, 50);
      settle_ring();

      // zero hold, push-heavy, one long receiver stall to back up the input
      write_reg(afva_pkg::CSR_ROOM_HEADROOM, 11'd1000);
      write_reg(afva_pkg::CSR_AMP_HOLD_FRAMES, 11'd0);
      idle_odds = 6;
      queue_traffic(500, 10);
      want_long_hold = 1'b1;
      settle_ring();

      // spare indexes must be ignored; upper data bits dropped on the hold
      write_reg(CSR_SPARE_IDX_A, 11'h7FF);
      write_reg(CSR_SPARE_IDX_B, 11'h000);
      write_reg(afva_pkg::CSR_ROOM_HEADROOM, 11'd1536);
      write_reg(afva_pkg::CSR_AMP_HOLD_FRAMES, 11'h503);
      idle_odds = 3;
      queue_traffic(350, 50);
      settle_ring();

      // closing stretch without idling
      write_reg(afva_pkg::CSR_ROOM_HEADROOM, 11'd400);
      write_reg(afva_pkg::CSR_AMP_HOLD_FRAMES, 11'd2);
      idle_odds = 0;
      queue_traffic(300, 50);
      settle_ring();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[audio_fifo_volume_amp_gate] OK");
      end else begin
         $display("[audio_fifo_volume_amp_gate] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("[audio_fifo_volume_amp_gate] ERROR");
      $finish;
   end

endmodule
